@@ rtl/rau_pkg.sv @@
package rau_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]                  opcode;
        logic [OPERAND_BITS_DEF-1:0] a_num;
        logic [OPERAND_BITS_DEF-2:0] a_den;
        logic [OPERAND_BITS_DEF-1:0] b_num;
        logic [OPERAND_BITS_DEF-2:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic [RES_NUM_W-1:0] result_num;
        logic [RES_DEN_W-1:0] result_den;
        logic                 div_by_zero;
    } t_out_item;

endpackage

@@ rtl/rau_front.sv @@
module rau_front #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF,
    parameter int MAG_W        = 2 * OPERAND_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_opcode,
    input  logic [OPERAND_BITS-1:0] i_a_num,
    input  logic [OPERAND_BITS-2:0] i_a_den,
    input  logic [OPERAND_BITS-1:0] i_b_num,
    input  logic [OPERAND_BITS-2:0] i_b_den,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [MAG_W-1:0]        o_t1,
    output logic [MAG_W-1:0]        o_t2,
    output logic [MAG_W-1:0]        o_dmag,
    output logic                    o_n1,
    output logic                    o_n2,
    output logic                    o_sum,
    output logic                    o_dz
);

    localparam int OB = OPERAND_BITS;

    logic            r_valid;
    logic [1:0]      r_op;
    logic [OB-1:0]   r_an, r_bn;
    logic [OB-2:0]   r_ad, r_bd;
    logic            r_an_neg, r_bn_neg;
    logic [OB-1:0]   an_mag, bn_mag;
    logic [OB-1:0]   x_l, y_l, x_r;
    logic [OB-2:0]   y_r;

    assign an_mag = i_a_num[OB-1] ? (~i_a_num + 1'b1) : i_a_num;
    assign bn_mag = i_b_num[OB-1] ? (~i_b_num + 1'b1) : i_b_num;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_op     <= i_opcode;
            r_an     <= an_mag;
            r_bn     <= bn_mag;
            r_ad     <= i_a_den;
            r_bd     <= i_b_den;
            r_an_neg <= i_a_num[OB-1];
            r_bn_neg <= i_b_num[OB-1];
        end
    end

    // classify and pick the multiplier operands
    always_comb begin
        x_l   = r_an;
        x_r   = {1'b0, r_bd};
        y_l   = r_bn;
        y_r   = r_ad;
        o_n1  = r_an_neg;
        o_n2  = r_bn_neg;
        o_sum = 1'b0;
        o_dz  = 1'b0;
        unique case (r_op)
            rau_pkg::OP_ADD: begin
                o_sum = 1'b1;
            end
            rau_pkg::OP_SUB: begin
                o_sum = 1'b1;
                o_n2  = !r_bn_neg;
            end
            rau_pkg::OP_MUL: begin
                x_r  = r_bn;
                o_n1 = r_an_neg ^ r_bn_neg;
            end
            default: begin
                o_dz = (r_bn == '0);
                o_n1 = o_dz ? r_an_neg : (r_an_neg ^ r_bn_neg);
            end
        endcase
    end

    assign o_t1   = MAG_W'(x_l) * MAG_W'(x_r);
    assign o_t2   = MAG_W'(y_l) * MAG_W'(y_r);
    assign o_dmag = (r_op == rau_pkg::OP_DIV) ? (MAG_W'(r_ad) * MAG_W'(r_bn))
                  : (MAG_W'(r_ad) * MAG_W'(r_bd));

endmodule

@@ rtl/rau_queue.sv @@
module rau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rau_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/rau_back.sv @@
module rau_back #(
    parameter int MAG_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [MAG_W-1:0]     i_t1,
    input  logic [MAG_W-1:0]     i_t2,
    input  logic [MAG_W-1:0]     i_dmag,
    input  logic                 i_n1,
    input  logic                 i_n2,
    input  logic                 i_sum,
    input  logic                 i_dz,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rau_pkg::t_out_item   o_item
);

    localparam int W  = MAG_W + 1;
    localparam int CW = $clog2(W + 1);
    localparam int XW = (W > rau_pkg::RES_NUM_W) ? W : rau_pkg::RES_NUM_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIVN = 3'd2;
    localparam logic [2:0] ST_DIVD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]    r_st;
    logic [W-1:0]  r_n, r_d, r_ga, r_gb;
    logic [W-1:0]  r_q, r_rem, r_qn;
    logic [CW-1:0] r_cnt;
    logic          r_neg, r_dz;
    logic [W-1:0]  nsum, t1w, t2w;
    logic [W-1:0]  rem_sh, q_sh, q_next, rem_next;
    logic          q_bit;
    logic [XW-1:0] qn_x, d_x, neg_q;
    logic          n_neg;

    assign t1w = W'(i_t1);
    assign t2w = W'(i_t2);

    always_comb begin
        n_neg = i_n1;
        nsum  = t1w;
        if (i_sum) begin
            if (i_n1 == i_n2) begin
                nsum = t1w + t2w;
            end else if (t1w >= t2w) begin
                nsum = t1w - t2w;
            end else begin
                nsum  = t2w - t1w;
                n_neg = i_n2;
            end
        end
    end

    // one restoring division step on the dividend in r_q
    assign rem_sh   = {r_rem[W-2:0], r_q[W-1]};
    assign q_sh     = {r_q[W-2:0], 1'b0};
    assign q_bit    = (rem_sh >= r_ga);
    assign q_next   = q_sh | W'(q_bit);
    assign rem_next = q_bit ? (rem_sh - r_ga) : rem_sh;

    assign qn_x  = XW'(r_qn);
    assign d_x   = XW'(r_d);
    assign neg_q = ~qn_x + 1'b1;

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = (r_st == ST_OUT);
    assign o_item.result_num  = r_neg ? neg_q[rau_pkg::RES_NUM_W-1:0]
                                      : qn_x[rau_pkg::RES_NUM_W-1:0];
    assign o_item.result_den  = d_x[rau_pkg::RES_DEN_W-1:0];
    assign o_item.div_by_zero = r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            unique case (r_st) inside
                ST_IDLE: begin
                    if (i_valid) begin
                        r_n   <= nsum;
                        r_ga  <= nsum;
                        r_gb  <= W'(i_dmag);
                        r_cnt <= '0;
                        r_dz  <= i_dz;
                        if (nsum == '0) begin
                            r_qn  <= '0;
                            r_neg <= 1'b0;
                            r_d   <= W'(1);
                            r_st  <= ST_OUT;
                        end else begin
                            r_d   <= W'(i_dmag);
                            r_neg <= n_neg;
                            r_st  <= ST_GCD;
                        end
                    end
                end
                ST_GCD: begin
                    // binary gcd, common factors of two counted in r_cnt
                    if (r_gb == '0 || r_ga == '0) begin
                        r_ga  <= (r_gb == '0) ? (r_ga << r_cnt) : (r_gb << r_cnt);
                        r_q   <= r_n;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_st  <= ST_DIVN;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga  <= r_ga >> 1;
                        r_gb  <= r_gb >> 1;
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga >= r_gb) begin
                        r_ga <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                ST_DIVN, ST_DIVD: begin
                    if (r_cnt == CW'(W - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (r_st == ST_DIVN) begin
                            r_qn <= q_next;
                            r_q  <= r_d;
                            r_st <= ST_DIVD;
                        end else begin
                            r_d  <= q_next;
                            r_st <= ST_OUT;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_rem <= rem_next;
                        r_q   <= q_next;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// channel   | handshake            | payload
// input     | i_valid / o_ready    | i_item  (opcode, a_num, a_den, b_num, b_den)
// output    | o_valid / i_ready    | o_item  (result_num, result_den, div_by_zero)
// front stage registers an item and forms the cross products from its registers
// a two-entry queue lets the front keep taking items while the back is busy
// back: binary gcd, one shift or subtract a cycle, then two bit-serial divisions
// by the gcd, of the numerator and then of the denominator
// a zero numerator skips the gcd and the divisions and goes straight to the output
// synchronous active-low reset empties the front, the queue and the back
// a stalled output holds the back; the queue then fills and o_ready drops
module rational_arithmetic_unit #(
    parameter int QUEUE_DEPTH = rau_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rau_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output rau_pkg::t_out_item o_item
);

    localparam int MAG_W = 2 * rau_pkg::OPERAND_BITS_DEF;
    localparam int QW    = 3 * MAG_W + 4;

    logic             f_valid, f_ready, q_valid, q_ready;
    logic [MAG_W-1:0] f_t1, f_t2, f_dmag, b_t1, b_t2, b_dmag;
    logic             f_n1, f_n2, f_sum, f_dz, b_n1, b_n2, b_sum, b_dz;

    rau_front #(.OPERAND_BITS(rau_pkg::OPERAND_BITS_DEF), .MAG_W(MAG_W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_item.opcode),
        .i_a_num  (i_item.a_num),
        .i_a_den  (i_item.a_den),
        .i_b_num  (i_item.b_num),
        .i_b_den  (i_item.b_den),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_t1     (f_t1),
        .o_t2     (f_t2),
        .o_dmag   (f_dmag),
        .o_n1     (f_n1),
        .o_n2     (f_n2),
        .o_sum    (f_sum),
        .o_dz     (f_dz)
    );

    rau_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_t1, f_t2, f_dmag, f_n1, f_n2, f_sum, f_dz}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  ({b_t1, b_t2, b_dmag, b_n1, b_n2, b_sum, b_dz})
    );

    rau_back #(.MAG_W(MAG_W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_t1    (b_t1),
        .i_t2    (b_t2),
        .i_dmag  (b_dmag),
        .i_n1    (b_n1),
        .i_n2    (b_n2),
        .i_sum   (b_sum),
        .i_dz    (b_dz),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

@@ test/tb_rational_arithmetic_unit.sv @@
module tb_rational_arithmetic_unit;

    localparam int OB = rau_pkg::OPERAND_BITS_DEF;
    localparam int IDLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 2000;
    localparam int RANDOM_ITEMS = 1250;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    rau_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_ready;
    rau_pkg::t_out_item o_item;

    rau_pkg::t_in_item  pending_items[$];
    rau_pkg::t_out_item expected_results[$];
    int        error_count;
    int        idle_cycles;
    int        accepted_count;
    logic      took_item;
    int        burst_left;
    int        gap_left;
    int        hold_left;
    bit        hold_done;

    rational_arithmetic_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned magnitude(logic [OB-1:0] v);
        longint unsigned full;
        full = 64'(v);
        return v[OB-1] ? ((64'd1 << OB) - full) : full;
    endfunction

    function automatic rau_pkg::t_out_item reduce_rational(rau_pkg::t_in_item it);
        rau_pkg::t_out_item res;
        longint unsigned an, ad, bn, bd, t1, t2, nmag, dmag, x, y, t;
        bit              an_neg, bn_neg, n2, neg, dz;
        an = magnitude(it.a_num);
        bn = magnitude(it.b_num);
        an_neg = it.a_num[OB-1];
        bn_neg = it.b_num[OB-1];
        ad = 64'(it.a_den);
        bd = 64'(it.b_den);
        neg = 1'b0;
        dz = 1'b0;
        case (it.opcode) inside
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                t1 = an * bd;
                t2 = bn * ad;
                n2 = (it.opcode == rau_pkg::OP_SUB) ? !bn_neg : bn_neg;
                if (an_neg == n2) begin
                    nmag = t1 + t2;
                    neg = an_neg;
                end else if (t1 >= t2) begin
                    nmag = t1 - t2;
                    neg = an_neg;
                end else begin
                    nmag = t2 - t1;
                    neg = n2;
                end
                dmag = ad * bd;
            end
            rau_pkg::OP_MUL: begin
                nmag = an * bn;
                dmag = ad * bd;
                neg = an_neg != bn_neg;
            end
            default: begin
                nmag = an * bd;
                dmag = ad * bn;
                dz = (bn == 0);
                neg = dz ? an_neg : (an_neg != bn_neg);
            end
        endcase
        if (nmag == 0) begin
            dmag = 1;
        end else begin
            x = nmag;
            y = dmag;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            nmag = nmag / x;
            dmag = dmag / x;
            if (neg)
                nmag = 64'd0 - nmag;
        end
        res.result_num = nmag[rau_pkg::RES_NUM_W-1:0];
        res.result_den = dmag[rau_pkg::RES_DEN_W-1:0];
        res.div_by_zero = dz;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic rau_pkg::t_in_item make_item(logic [1:0] op, int an, int ad,
                                                    int bn, int bd);
        rau_pkg::t_in_item it;
        it.opcode = op;
        it.a_num = an[OB-1:0];
        it.a_den = ad[OB-2:0];
        it.b_num = bn[OB-1:0];
        it.b_den = bd[OB-2:0];
        return it;
    endfunction

    function automatic int rand_den();
        case ($urandom_range(0, 9)) inside
            0: return 1;
            1: return 32767;
            2: return 0;
            3, 4: return $urandom_range(1, 15);
            default: return $urandom_range(1, 32767);
        endcase
    endfunction

    function automatic int rand_num();
        case ($urandom_range(0, 9)) inside
            0: return 0;
            1: return -32768;
            2: return 32767;
            3, 4: return $urandom_range(0, 30) - 15;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    // driver
    always @(negedge i_clk) begin
        logic              next_valid;
        rau_pkg::t_in_item next_item;
        next_valid = i_valid && !took_item;
        next_item = i_item;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 8);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
                end
            end
        end
        i_valid <= next_valid;
        i_item <= next_item;
    end

    // receiver stall pattern, with one long hold to back the block up
    always @(negedge i_clk) begin
        if (!hold_done && accepted_count >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (accepted_count / 200 % 2 == 1) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rau_pkg::t_out_item want;
        took_item <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_valid && o_ready) begin
                expected_results.push_back(reduce_rational(i_item));
                accepted_count++;
                idle_cycles = 0;
            end
            if (o_valid && i_ready) begin
                idle_cycles = 0;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result_num", $signed(o_item.result_num), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_item.result_num !== want.result_num)
                        report_mismatch("result_num", $signed(o_item.result_num),
                                        $signed(want.result_num));
                    if (o_item.result_den !== want.result_den)
                        report_mismatch("result_den", o_item.result_den, want.result_den);
                    if (o_item.div_by_zero !== want.div_by_zero)
                        report_mismatch("div_by_zero", o_item.div_by_zero,
                                        want.div_by_zero);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        accepted_count = 0;
        took_item = 1'b0;
        burst_left = 0;
        gap_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_item = '0;

        // extremes, every operation, zero numerators and division by zero
        pending_items.push_back(make_item(rau_pkg::OP_ADD, 1, 2, 1, 3));
        pending_items.push_back(make_item(rau_pkg::OP_SUB, 1, 2, 1, 2));
        pending_items.push_back(make_item(rau_pkg::OP_MUL, -3, 4, 4, 3));
        pending_items.push_back(make_item(rau_pkg::OP_DIV, 5, 7, -10, 21));
        pending_items.push_back(make_item(rau_pkg::OP_DIV, -5, 7, 0, 1));
        pending_items.push_back(make_item(rau_pkg::OP_DIV, 5, 7, 0, 3));
        pending_items.push_back(make_item(rau_pkg::OP_DIV, 0, 7, 0, 3));
        pending_items.push_back(make_item(rau_pkg::OP_MUL, 0, 9, -7, 5));
        pending_items.push_back(make_item(rau_pkg::OP_ADD, -32768, 1, -32768, 1));
        pending_items.push_back(make_item(rau_pkg::OP_SUB, 32767, 1, -32768, 1));
        pending_items.push_back(make_item(rau_pkg::OP_MUL, -32768, 1, -32768, 1));
        pending_items.push_back(make_item(rau_pkg::OP_MUL, 32767, 32767, 32767, 32767));
        pending_items.push_back(make_item(rau_pkg::OP_DIV, -32768, 1, 1, 32767));
        pending_items.push_back(make_item(rau_pkg::OP_ADD, 1, 32767, 1, 32766));
        pending_items.push_back(make_item(rau_pkg::OP_ADD, 6, 4, 10, 8));
        pending_items.push_back(make_item(rau_pkg::OP_ADD, 3, 0, 2, 5));
        pending_items.push_back(make_item(rau_pkg::OP_MUL, -3, 0, 2, 5));
        pending_items.push_back(make_item(rau_pkg::OP_SUB, 0, 0, 0, 0));
        pending_items.push_back(make_item(rau_pkg::OP_DIV, 4, 0, 2, 3));
        pending_items.push_back(make_item(rau_pkg::OP_DIV, 4, 3, 2, 0));
        pending_items.push_back(make_item(rau_pkg::OP_SUB, -32768, 32767, 32767, 32767));
        pending_items.push_back(make_item(rau_pkg::OP_MUL, -32768, 3, 32767, 5));
        repeat (RANDOM_ITEMS)
            pending_items.push_back(make_item(2'($urandom_range(0, 3)), rand_num(),
                                              rand_den(), rand_num(), rand_den()));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
